// ===== sv/led_pulse_channel_controller_core_macros.svh =====
// Assertion macros for the LED pulse channel controller.
// Used by the top level only; the bodies are empty when SYNTHESIS is defined.
`ifndef LED_PULSE_CHANNEL_CONTROLLER_CORE_MACROS_SVH
`define LED_PULSE_CHANNEL_CONTROLLER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define LPCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("LPCC assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define LPCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("LPCC assertion failed");
`else
`define LPCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define LPCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/lpcc_pkg.sv =====
// Shared constants for the LED pulse channel controller.
// No dependencies; imported by the top level.
`default_nettype none

package lpcc_pkg;

    // Default number of channels and fixed field widths.
    localparam int NUM_CHANNELS_DEF = 8;
    localparam int PIN_W            = 8;
    localparam int CMD_W            = 3;
    localparam int HOLD_W           = 8;
    localparam int ENTRY_W          = CMD_W + HOLD_W;
    localparam int APB_AW           = 3;
    localparam int APB_DW           = 32;

    // Request types.
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_BLOCK = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_IDLE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_OFF  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ON   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POS  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_NEG  = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BLOCKED  = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_DISABLED = 2'd3;

    // Register indexes, taken from paddr[2].
    localparam logic REG_WRITE_ENABLE = 1'b0;
    localparam logic REG_PULSE_LENGTH = 1'b1;

    // Operation carried from the accept cycle into the execute cycles.
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_BLOCK = 2'd2,
        OP_TICK  = 2'd3
    } t_op;

endpackage

`default_nettype wire

// ===== sv/lpcc_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module lpcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic                                       i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/led_pulse_channel_controller_core.sv =====
// Top level of the LED pulse channel controller: sequencer, registers and APB port.
// Depends on lpcc_pkg, lpcc_ram and the assertion macro header.
`default_nettype none
`include "led_pulse_channel_controller_core_macros.svh"

// Each channel's pending command and hold counter live in one RAM entry with a
// registered read; block bits and pin levels are flip-flops. A write or block
// beat passes through the accept, read-modify-write and result states. A tick
// beat walks the channels one RAM entry per cycle, from the first to the last.
// A result that is still stalled at the output holds the next result back by
// the time it stays. Entries carry valid bits cleared by reset, so no clearing
// pass follows reset. One result beat is produced for every input beat;
// pin_levels shows channels 0 to 7.
module led_pulse_channel_controller_core #(
    parameter int NUM_CHANNELS = lpcc_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Input beats.
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_req_type,
    input  wire logic [7:0]                    i_channel,
    input  wire logic [lpcc_pkg::CMD_W-1:0]    i_command,
    input  wire logic                          i_block_flag,
    // Result beats.
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [1:0]                         o_status,
    output logic [lpcc_pkg::PIN_W-1:0]         o_pin_levels,
    // Configuration port.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lpcc_pkg::APB_AW-1:0]   paddr,
    input  wire logic [lpcc_pkg::APB_DW-1:0]   pwdata,
    output logic [lpcc_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);

    import lpcc_pkg::*;

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CH_W-1:0] IDX_LAST = CH_W'(NUM_CHANNELS - 1);
    localparam logic [7:0] CH_LIMIT = 8'(NUM_CHANNELS);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } t_state;

    // Control state.
    t_state                    r_state, n_state;
    t_op                       r_op, n_op;
    logic [CH_W-1:0]           r_idx, n_idx;
    logic [NUM_CHANNELS-1:0]   r_valid;
    logic [NUM_CHANNELS-1:0]   r_block, n_block;
    logic [NUM_CHANNELS-1:0]   r_pin, n_pin;
    logic                      r_out_valid, n_out_valid;
    logic                      r_wr_en;
    logic [HOLD_W-1:0]         r_pulse_len;

    // Payload held across the execute cycles and at the output.
    logic [1:0]                r_res_status, n_res_status;
    logic [CMD_W-1:0]          r_cmd;
    logic                      r_blk;
    logic [1:0]                r_status;
    logic [PIN_W-1:0]          r_pin_out;

    // RAM port signals.
    logic                      ram_we, ram_re;
    logic [CH_W-1:0]           ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]        ram_wdata, ram_rdata;

    // Decoded entry and its updated value.
    logic [CMD_W-1:0]          ent_cmd, new_cmd;
    logic [HOLD_W-1:0]         ent_hold, new_hold;
    logic                      in_acc, cfg_wr, in_range, out_free;
    logic [PIN_W-1:0]          pin_view;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign in_range = (i_channel < CH_LIMIT);
    assign out_free = !r_out_valid || !i_out_stall;

    // State RAM: {pending command, hold counter} per channel.
    lpcc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_CHANNELS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // An entry never written since reset reads as idle with a zero counter.
    assign ent_cmd  = r_valid[r_idx] ? ram_rdata[ENTRY_W-1:HOLD_W] : CMD_IDLE;
    assign ent_hold = r_valid[r_idx] ? ram_rdata[HOLD_W-1:0] : '0;

    // Configuration registers and read-back.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_en     <= 1'b0;
            r_pulse_len <= '0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_WRITE_ENABLE: r_wr_en     <= pwdata[0];
                REG_PULSE_LENGTH: r_pulse_len <= pwdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WRITE_ENABLE: prdata = {{(APB_DW-1){1'b0}}, r_wr_en};
            REG_PULSE_LENGTH: prdata = {{(APB_DW-HOLD_W){1'b0}}, r_pulse_len};
            default:          prdata = '0;
        endcase
    end

    // Sequencer: classify the beat, read-modify-write the RAM, then present the result.
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_idx        = r_idx;
        n_block      = r_block;
        n_pin        = r_pin;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && i_out_stall;
        ram_re       = 1'b0;
        ram_raddr    = i_channel[CH_W-1:0];
        ram_we       = 1'b0;
        ram_waddr    = r_idx;
        new_cmd      = ent_cmd;
        new_hold     = ent_hold;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state      = S_EXEC;
                    n_res_status = ST_OK;
                    n_op         = OP_NONE;
                    n_idx        = i_channel[CH_W-1:0];
                    case (i_req_type)
                        REQ_WRITE: begin
                            if (!r_wr_en) begin
                                n_res_status = ST_DISABLED;
                            end else if (!in_range) begin
                                n_res_status = ST_RANGE;
                            end else if (r_block[i_channel[CH_W-1:0]]) begin
                                n_res_status = ST_BLOCKED;
                            end else begin
                                n_op = OP_WRITE;
                            end
                        end
                        REQ_BLOCK: begin
                            if (!in_range) begin
                                n_res_status = ST_RANGE;
                            end else begin
                                n_op = OP_BLOCK;
                            end
                        end
                        REQ_TICK: begin
                            n_op  = OP_TICK;
                            n_idx = '0;
                        end
                        default: ;
                    endcase
                    ram_re    = (n_op != OP_NONE);
                    ram_raddr = n_idx;
                end
            end

            S_EXEC: begin
                n_state = S_DONE;
                case (r_op)
                    OP_WRITE: begin
                        new_cmd = (r_cmd <= CMD_NEG) ? r_cmd : CMD_IDLE;
                        ram_we  = 1'b1;
                    end
                    OP_BLOCK: begin
                        n_block[r_idx] = r_blk;
                        if (r_blk) begin
                            new_cmd = CMD_OFF;
                            ram_we  = 1'b1;
                        end
                    end
                    OP_TICK: begin
                        // One channel per cycle; the next entry is read meanwhile.
                        if (ent_cmd == CMD_OFF || ent_cmd == CMD_ON) begin
                            if (ent_hold == '0) begin
                                n_pin[r_idx] = (ent_cmd == CMD_ON);
                                new_cmd      = CMD_IDLE;
                            end else begin
                                new_hold = ent_hold - HOLD_W'(1);
                            end
                        end else if (ent_cmd == CMD_POS) begin
                            new_hold     = r_pulse_len;
                            n_pin[r_idx] = 1'b1;
                            new_cmd      = CMD_OFF;
                        end else if (ent_cmd == CMD_NEG) begin
                            new_hold     = r_pulse_len;
                            n_pin[r_idx] = 1'b0;
                            new_cmd      = CMD_ON;
                        end
                        ram_we = 1'b1;
                        if (r_idx != IDX_LAST) begin
                            n_state   = S_EXEC;
                            n_idx     = r_idx + CH_W'(1);
                            ram_re    = 1'b1;
                            ram_raddr = n_idx;
                        end
                    end
                    default: ;
                endcase
            end

            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    assign ram_wdata = {new_cmd, new_hold};

    // Pins beyond the channel count read as off; only channels 0 to 7 are shown.
    always_comb begin
        for (int k = 0; k < PIN_W; k++) begin
            pin_view[k] = (k < NUM_CHANNELS) ? r_pin[k] : 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_NONE;
            r_idx       <= '0;
            r_valid     <= '0;
            r_block     <= '0;
            r_pin       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_idx       <= n_idx;
            r_block     <= n_block;
            r_pin       <= n_pin;
            r_out_valid <= n_out_valid;
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
        end
    end

    // Beat payload and result registers.
    always_ff @(posedge i_clk) begin
        r_res_status <= n_res_status;
        if (in_acc) begin
            r_cmd <= i_command;
            r_blk <= i_block_flag;
        end
        if (r_state == S_DONE && out_free) begin
            r_status  <= r_res_status;
            r_pin_out <= pin_view;
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_pin_levels = r_pin_out;

    // Checks on the sequencer and the RAM access pattern.
    `LPCC_ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, in_acc, r_state == S_EXEC)
    `LPCC_ASSERT_IMPL(a_no_rw_clash, i_clk, i_rst_n, ram_we && ram_re, ram_waddr != ram_raddr)
    `LPCC_ASSERT_IMPL(a_idx_range, i_clk, i_rst_n, r_state == S_EXEC, r_idx <= IDX_LAST)
    `LPCC_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, r_state == S_DONE && out_free, r_out_valid && r_state == S_IDLE)

endmodule

`default_nettype wire

// ===== sim/led_pulse_channel_controller_core_tb.sv =====
// Self-checking testbench for the LED pulse channel controller top level.
// Depends on lpcc_pkg and led_pulse_channel_controller_core, and through it on lpcc_ram and the macro header.
`timescale 1ns / 100ps

module led_pulse_channel_controller_core_tb;

    import lpcc_pkg::*;

    localparam int NUM_CH       = NUM_CHANNELS_DEF;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_ITEMS  = 300;
    localparam int NUM_PHASES   = 6;

    // The request code that the block ignores.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Byte addresses of the two configuration registers.
    localparam logic [APB_AW-1:0] ADDR_WRITE_ENABLE = {REG_WRITE_ENABLE, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_PULSE_LENGTH = {REG_PULSE_LENGTH, 2'b00};

    typedef struct {
        logic [1:0]       status;
        logic [PIN_W-1:0] pins;
    } t_pin_result;

    typedef struct {
        logic [1:0]       req;
        logic [7:0]       ch;
        logic [CMD_W-1:0] cmd;
        logic             blk;
        bit               fixed;
        logic [1:0]       fix_status;
        logic [PIN_W-1:0] fix_pins;
    } t_led_row;

    // Block inputs, all known from time zero.
    logic              i_clk        = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic [1:0]        req_type     = '0;
    logic [7:0]        channel      = '0;
    logic [CMD_W-1:0]  command      = '0;
    logic              block_flag   = 1'b0;
    logic              out_stall    = 1'b0;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [APB_AW-1:0] paddr        = '0;
    logic [APB_DW-1:0] pwdata       = '0;

    // Block outputs.
    wire               o_in_stall;
    wire               o_out_valid;
    wire [1:0]         o_status;
    wire [PIN_W-1:0]   o_pin_levels;
    wire [APB_DW-1:0]  prdata;
    wire               pready;

    // Typed expectation travelling with the current input beat.
    bit                beat_fixed      = 1'b0;
    logic [1:0]        beat_fix_status = '0;
    logic [PIN_W-1:0]  beat_fix_pins   = '0;

    // Own copy of the channel bank and its configuration.
    logic              mdl_write_en;
    logic [7:0]        mdl_pulse_len;
    logic [CMD_W-1:0]  mdl_pending [NUM_CH];
    logic [HOLD_W-1:0] mdl_hold    [NUM_CH];
    logic [NUM_CH-1:0] mdl_block;
    logic [NUM_CH-1:0] mdl_pins;

    t_pin_result       status_pins_due [$];
    t_led_row          led_rows [$];
    int                error_count = 0;
    int                burst_left  = 0;

    // Receiver stall pattern state.
    logic [1:0]        stall_mode = 2'd0;
    logic [7:0]        stall_cnt  = '0;

    // Monitor scratch.
    logic [1:0]        got_status;
    logic [PIN_W-1:0]  got_pins;
    t_pin_result       due;

    led_pulse_channel_controller_core #(
        .NUM_CHANNELS (NUM_CH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (req_type),
        .i_channel    (channel),
        .i_command    (command),
        .i_block_flag (block_flag),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .o_status     (o_status),
        .o_pin_levels (o_pin_levels),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Clock with a 4 ns period.
    always #2 i_clk = ~i_clk;

    // Run limit, well beyond the slowest correct run.
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    // Apply one input beat to the channel bank and work out its result.
    task automatic led_bank_step(input logic [1:0] rq, input logic [7:0] ch,
                                 input logic [CMD_W-1:0] cm, input logic bf,
                                 output logic [1:0] st, output logic [PIN_W-1:0] pins);
        st = ST_OK;
        case (rq)
            REQ_WRITE: begin
                if (!mdl_write_en) begin
                    st = ST_DISABLED;
                end else if (ch >= NUM_CH) begin
                    st = ST_RANGE;
                end else if (mdl_block[ch]) begin
                    st = ST_BLOCKED;
                end else begin
                    mdl_pending[ch] = (cm <= CMD_NEG) ? cm : CMD_IDLE;
                end
            end
            REQ_BLOCK: begin
                if (ch >= NUM_CH) begin
                    st = ST_RANGE;
                end else if (!bf) begin
                    mdl_block[ch] = 1'b0;
                end else begin
                    // Blocking queues an off level but keeps the hold counter.
                    mdl_block[ch]   = 1'b1;
                    mdl_pending[ch] = CMD_OFF;
                end
            end
            REQ_TICK: begin
                for (int k = 0; k < NUM_CH; k++) begin
                    case (mdl_pending[k])
                        CMD_OFF, CMD_ON: begin
                            if (mdl_hold[k] == '0) begin
                                mdl_pins[k]    = (mdl_pending[k] == CMD_ON);
                                mdl_pending[k] = CMD_IDLE;
                            end else begin
                                mdl_hold[k] = mdl_hold[k] - 1'b1;
                            end
                        end
                        CMD_POS: begin
                            mdl_hold[k]    = mdl_pulse_len;
                            mdl_pins[k]    = 1'b1;
                            mdl_pending[k] = CMD_OFF;
                        end
                        CMD_NEG: begin
                            mdl_hold[k]    = mdl_pulse_len;
                            mdl_pins[k]    = 1'b0;
                            mdl_pending[k] = CMD_ON;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        pins = PIN_W'(mdl_pins);
    endtask

    // Predict each accepted input beat and check each accepted result beat.
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (in_valid && !o_in_stall) begin
                led_bank_step(req_type, channel, command, block_flag, got_status, got_pins);
                if (beat_fixed)
                    status_pins_due.push_back('{status: beat_fix_status, pins: beat_fix_pins});
                else
                    status_pins_due.push_back('{status: got_status, pins: got_pins});
            end
            if (o_out_valid && !out_stall) begin
                if (status_pins_due.size() == 0) begin
                    $error("result beat with no expectation: status %0d pin_levels %h",
                           o_status, o_pin_levels);
                    error_count++;
                end else begin
                    due = status_pins_due.pop_front();
                    if (o_status !== due.status) begin
                        $error("status: expected %0d, got %0d", due.status, o_status);
                        error_count++;
                    end
                    if (o_pin_levels !== due.pins) begin
                        $error("pin_levels: expected %h, got %h", due.pins, o_pin_levels);
                        error_count++;
                    end
                end
            end
        end
    end

    // Receiver stall: a new pattern is picked each time the stall counter wraps.
    always @(posedge i_clk) begin
        stall_cnt <= stall_cnt + 1'b1;
        if (stall_cnt == 8'hFF)
            stall_mode <= 2'($urandom_range(0, 3));
        case (stall_mode)
            2'd0: out_stall <= 1'b0;
            2'd1: out_stall <= ($urandom_range(0, 9) < 3);
            2'd2: out_stall <= (stall_cnt[2:0] >= 3'd5);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    task automatic add_row(input logic [1:0] rq, input logic [7:0] ch,
                           input logic [CMD_W-1:0] cm, input logic bf, input bit fx,
                           input logic [1:0] fst, input logic [PIN_W-1:0] fpins);
        led_rows.push_back('{req: rq, ch: ch, cmd: cm, blk: bf, fixed: fx,
                             fix_status: fst, fix_pins: fpins});
    endtask

    // Send one beat, with a random gap at the start of each burst.
    task automatic drive_beat(input logic [1:0] rq, input logic [7:0] ch,
                              input logic [CMD_W-1:0] cm, input logic bf, input bit fx,
                              input logic [1:0] fst, input logic [PIN_W-1:0] fpins);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_valid        <= 1'b1;
        req_type        <= rq;
        channel         <= ch;
        command         <= cm;
        block_flag      <= bf;
        beat_fixed      <= fx;
        beat_fix_status <= fst;
        beat_fix_pins   <= fpins;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Hold the sender off until every expected result has arrived.
    task automatic wait_drained();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (status_pins_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write: setup cycle, access cycle until pready, then the bus returns to idle.
    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (addr == ADDR_WRITE_ENABLE)
            mdl_write_en = data[0];
        else
            mdl_pulse_len = data[7:0];
    endtask

    initial begin : stimulus
        int               dir_split;
        int               r;
        int               tick_pct;
        int               phase_we [NUM_PHASES];
        int               phase_pl [NUM_PHASES];
        logic [1:0]       rq;
        logic [7:0]       ch;
        logic [CMD_W-1:0] cm;
        logic             bf;

        phase_we = '{1, 1, 0, 1, 1, 1};
        phase_pl = '{0, 255, 3, 1, 2, 0};

        // Channel bank after reset.
        mdl_write_en  = 1'b0;
        mdl_pulse_len = '0;
        mdl_block     = '0;
        mdl_pins      = '0;
        for (int k = 0; k < NUM_CH; k++) begin
            mdl_pending[k] = CMD_IDLE;
            mdl_hold[k]    = '0;
        end

        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows with writing still disabled after reset.
        add_row(REQ_WRITE,  8'd0,   CMD_ON,   1'b0, 1, ST_DISABLED, '0);
        add_row(REQ_WRITE,  8'd255, 3'd7,     1'b1, 1, ST_DISABLED, '0);
        add_row(REQ_TICK,   8'd0,   CMD_IDLE, 1'b0, 1, ST_OK,       '0);
        add_row(REQ_UNUSED, 8'd255, 3'd7,     1'b1, 1, ST_OK,       '0);
        add_row(REQ_BLOCK,  8'd200, CMD_IDLE, 1'b1, 1, ST_RANGE,    '0);
        add_row(REQ_BLOCK,  8'd0,   CMD_IDLE, 1'b1, 1, ST_OK,       '0);
        add_row(REQ_BLOCK,  8'd0,   CMD_IDLE, 1'b0, 1, ST_OK,       '0);
        dir_split = led_rows.size();
        // Writing enabled, pulses held for no extra ticks.
        add_row(REQ_WRITE,  8'd8,   CMD_ON,   1'b0, 1, ST_RANGE,    '0);
        add_row(REQ_WRITE,  8'd255, CMD_NEG,  1'b1, 1, ST_RANGE,    '0);
        add_row(REQ_WRITE,  8'd0,   CMD_ON,   1'b0, 1, ST_OK,       '0);
        add_row(REQ_WRITE,  8'd7,   CMD_POS,  1'b0, 1, ST_OK,       '0);
        add_row(REQ_TICK,   8'd0,   CMD_IDLE, 1'b0, 0, ST_OK,       '0);
        add_row(REQ_TICK,   8'd0,   CMD_IDLE, 1'b0, 0, ST_OK,       '0);
        add_row(REQ_BLOCK,  8'd3,   CMD_IDLE, 1'b1, 0, ST_OK,       '0);
        add_row(REQ_WRITE,  8'd3,   CMD_ON,   1'b0, 0, ST_OK,       '0);
        add_row(REQ_BLOCK,  8'd3,   CMD_IDLE, 1'b0, 0, ST_OK,       '0);
        add_row(REQ_WRITE,  8'd3,   3'd5,     1'b0, 0, ST_OK,       '0);
        add_row(REQ_WRITE,  8'd3,   3'd7,     1'b1, 0, ST_OK,       '0);
        add_row(REQ_WRITE,  8'd2,   CMD_NEG,  1'b0, 0, ST_OK,       '0);
        add_row(REQ_WRITE,  8'd1,   CMD_ON,   1'b0, 0, ST_OK,       '0);
        add_row(REQ_TICK,   8'd0,   CMD_IDLE, 1'b0, 0, ST_OK,       '0);
        add_row(REQ_WRITE,  8'd4,   CMD_POS,  1'b0, 0, ST_OK,       '0);
        add_row(REQ_WRITE,  8'd4,   CMD_IDLE, 1'b0, 0, ST_OK,       '0);
        add_row(REQ_TICK,   8'd0,   CMD_IDLE, 1'b0, 0, ST_OK,       '0);
        add_row(REQ_TICK,   8'd0,   CMD_IDLE, 1'b0, 0, ST_OK,       '0);
        add_row(REQ_WRITE,  8'd6,   CMD_OFF,  1'b0, 0, ST_OK,       '0);
        add_row(REQ_TICK,   8'd0,   CMD_IDLE, 1'b0, 0, ST_OK,       '0);

        foreach (led_rows[i]) begin
            if (i == dir_split) begin
                wait_drained();
                apb_write(ADDR_WRITE_ENABLE, 32'd1);
                apb_write(ADDR_PULSE_LENGTH, 32'd0);
            end
            drive_beat(led_rows[i].req, led_rows[i].ch, led_rows[i].cmd, led_rows[i].blk,
                       led_rows[i].fixed, led_rows[i].fix_status, led_rows[i].fix_pins);
        end

        // Random phases, each under its own register setting.
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            if (p == NUM_PHASES - 1)
                phase_pl[p] = $urandom_range(0, 7);
            apb_write(ADDR_WRITE_ENABLE, APB_DW'(phase_we[p]));
            apb_write(ADDR_PULSE_LENGTH, APB_DW'(phase_pl[p]));
            // Long pulses need many more ticks to reach the end of their hold.
            tick_pct = (phase_pl[p] > 100) ? 70 : 35;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2)
                    wait_drained();
                ch = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, NUM_CH - 1));
                cm = ($urandom_range(0, 9) == 0) ? CMD_W'($urandom_range(5, 7))
                                                 : CMD_W'($urandom_range(0, 4));
                bf = 1'($urandom_range(0, 1));
                r  = $urandom_range(0, 99);
                if (r < tick_pct)
                    rq = REQ_TICK;
                else if (r < 95 - (100 - tick_pct) / 4)
                    rq = REQ_WRITE;
                else if (r < 97)
                    rq = REQ_BLOCK;
                else
                    rq = REQ_UNUSED;
                drive_beat(rq, ch, cm, bf, 0, ST_OK, '0);
            end
        end

        wait_drained();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
